// ===== hdl/rwlt_pkg.sv =====
`timescale 1ns / 1ps

package rwlt_pkg;

    localparam int IDX_W    = 6;
    localparam int GEN_W    = 16;
    localparam int REQ_IN_W = 8;
    localparam int COUNT_W  = 9;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [2:0] {
        OP_UNLOCK  = 3'd0,
        OP_READ    = 3'd1,
        OP_INTENT  = 3'd2,
        OP_PROMOTE = 3'd3,
        OP_WRITE   = 3'd4,
        OP_DEMOTE  = 3'd5,
        OP_DELETE  = 3'd6,
        OP_CREATE  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_ABSENT = 3'd0,
        ST_FREE   = 3'd1,
        ST_READ   = 3'd2,
        ST_INTENT = 3'd3,
        ST_WRITE  = 3'd4
    } slot_state_t;

    typedef enum logic [2:0] {
        RS_GRANTED  = 3'd0,
        RS_WAIT     = 3'd1,
        RS_NOLOCK   = 3'd2,
        RS_MISUSE   = 3'd3,
        RS_NOTOWNER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        WK_NONE = 2'd0,
        WK_ONE  = 2'd1,
        WK_ALL  = 2'd2
    } wake_t;

    typedef struct packed {
        logic    write_en;
        logic    gen_advance;
        status_t status;
        wake_t   wake;
    } eng_ctl_t;

endpackage

// ===== hdl/read_intend_write_lock_table.sv =====
`timescale 1ns / 1ps

// Table of reader/writer locks with an upgradeable read-intend-write mode.
// Each input word is one request (operation, slot, generation id, requester)
// and yields exactly one result word with a status, a wake hint, the slot's
// state and holder count afterward, and the id handed out by a create. A
// request that cannot be granted now returns must-wait and changes nothing;
// the requester retries. The block takes one request per cycle unless the
// result port stalls it: the slot table is read into a register when a
// request is taken, and once the result register can take it the request is
// decided, the slot written back and the result register loaded, with the
// write forwarded to a request for the same slot taken in that same cycle.
// No clearing pass is needed after reset; slots come up absent.
module read_intend_write_lock_table #(
    parameter int NUM_LOCKS      = 64,
    parameter int MAX_READERS    = 255,
    parameter int REQUESTER_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // req_type[2:0], lock_index[8:3], handle_id[24:9], requester[32:25]
    input  logic [rwlt_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status[2:0], wake[4:3], new_state[7:5], reader_count[16:8], new_id[32:17]
    output logic [rwlt_pkg::OUT_W-1:0] m_tdata
);

    localparam int SLOT_SPACE = 1 << rwlt_pkg::IDX_W;
    localparam int DEPTH  = (NUM_LOCKS < SLOT_SPACE) ? NUM_LOCKS : SLOT_SPACE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RD_W   = $clog2(MAX_READERS + 1);
    localparam int OWN_W  = REQUESTER_BITS + 1;
    localparam int GEN_W  = rwlt_pkg::GEN_W;

    logic                        accept;
    logic                        fire;
    logic                        req_valid_reg;
    logic                        req_valid_next;
    rwlt_pkg::op_t               op_reg;
    logic [rwlt_pkg::IDX_W-1:0]  idx_reg;
    logic [GEN_W-1:0]            id_reg;
    logic [REQUESTER_BITS-1:0]   who_reg;
    logic [rwlt_pkg::IDX_W-1:0]  in_idx;
    logic                        in_range;
    logic [OWN_W-1:0]            mine;
    logic [GEN_W-1:0]            gen_reg;

    rwlt_pkg::slot_state_t       cur_state;
    logic [RD_W-1:0]             cur_readers;
    logic [OWN_W-1:0]            cur_intent;
    logic [OWN_W-1:0]            cur_write;
    logic [GEN_W-1:0]            cur_generation;
    rwlt_pkg::slot_state_t       nxt_state;
    logic [RD_W-1:0]             nxt_readers;
    logic [OWN_W-1:0]            nxt_intent;
    logic [OWN_W-1:0]            nxt_write;
    logic [GEN_W-1:0]            nxt_generation;
    logic [GEN_W-1:0]            gen_next;
    logic [GEN_W-1:0]            new_id;
    rwlt_pkg::eng_ctl_t          ctl;

    rwlt_pkg::slot_state_t       rep_state;
    logic signed [rwlt_pkg::COUNT_W-1:0] rep_count;
    logic                        m_tvalid_reg;
    logic                        m_tvalid_next;
    logic [rwlt_pkg::OUT_W-1:0]  m_tdata_reg;

    assign accept   = s_tvalid && s_tready;
    assign fire     = req_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !req_valid_reg || fire;
    assign in_idx   = s_tdata[8:3];

    assign req_valid_next = accept ? 1'b1 : (fire ? 1'b0 : req_valid_reg);
    assign m_tvalid_next  = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            gen_reg       <= GEN_W'(1);
        end else begin
            req_valid_reg <= req_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (fire && ctl.gen_advance) begin
                gen_reg <= gen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= rwlt_pkg::op_t'(s_tdata[2:0]);
            idx_reg <= in_idx;
            id_reg  <= s_tdata[24:9];
            who_reg <= REQUESTER_BITS'(s_tdata[32:25]);
        end
        if (fire) begin
            m_tdata_reg <= {7'b0, new_id, rep_count, rep_state, ctl.wake, ctl.status};
        end
    end

    assign in_range = (32'(idx_reg) < 32'(NUM_LOCKS));
    assign mine     = {1'b1, who_reg};

    rwlt_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .RD_W   (RD_W),
        .OWN_W  (OWN_W)
    ) u_table (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rd_en           (accept),
        .rd_addr         (in_idx[ADDR_W-1:0]),
        .wr_en           (fire && ctl.write_en),
        .wr_addr         (idx_reg[ADDR_W-1:0]),
        .wr_state        (nxt_state),
        .wr_readers      (nxt_readers),
        .wr_intent_owner (nxt_intent),
        .wr_write_owner  (nxt_write),
        .wr_generation   (nxt_generation),
        .rd_state        (cur_state),
        .rd_readers      (cur_readers),
        .rd_intent_owner (cur_intent),
        .rd_write_owner  (cur_write),
        .rd_generation   (cur_generation)
    );

    rwlt_engine #(
        .RD_W        (RD_W),
        .OWN_W       (OWN_W),
        .MAX_READERS (MAX_READERS)
    ) u_engine (
        .in_range         (in_range),
        .op               (op_reg),
        .handle_id        (id_reg),
        .mine             (mine),
        .cur_state        (cur_state),
        .cur_readers      (cur_readers),
        .cur_intent_owner (cur_intent),
        .cur_write_owner  (cur_write),
        .cur_generation   (cur_generation),
        .gen_counter      (gen_reg),
        .nxt_state        (nxt_state),
        .nxt_readers      (nxt_readers),
        .nxt_intent_owner (nxt_intent),
        .nxt_write_owner  (nxt_write),
        .nxt_generation   (nxt_generation),
        .gen_counter_next (gen_next),
        .new_id           (new_id),
        .ctl              (ctl)
    );

    always_comb begin
        if (!in_range) begin
            rep_state = rwlt_pkg::ST_ABSENT;
            rep_count = '0;
        end else if (nxt_state == rwlt_pkg::ST_WRITE) begin
            rep_state = nxt_state;
            rep_count = '1;
        end else begin
            rep_state = nxt_state;
            rep_count = rwlt_pkg::COUNT_W'(nxt_readers);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/rwlt_table.sv =====
`timescale 1ns / 1ps

module rwlt_table #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int RD_W   = 8,
    parameter int OWN_W  = 9
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  rwlt_pkg::slot_state_t     wr_state,
    input  logic [RD_W-1:0]           wr_readers,
    input  logic [OWN_W-1:0]          wr_intent_owner,
    input  logic [OWN_W-1:0]          wr_write_owner,
    input  logic [rwlt_pkg::GEN_W-1:0] wr_generation,
    output rwlt_pkg::slot_state_t     rd_state,
    output logic [RD_W-1:0]           rd_readers,
    output logic [OWN_W-1:0]          rd_intent_owner,
    output logic [OWN_W-1:0]          rd_write_owner,
    output logic [rwlt_pkg::GEN_W-1:0] rd_generation
);

    rwlt_pkg::slot_state_t          mem_state      [DEPTH];
    logic [RD_W-1:0]                mem_readers    [DEPTH];
    logic [OWN_W-1:0]               mem_intent     [DEPTH];
    logic [OWN_W-1:0]               mem_write      [DEPTH];
    logic [rwlt_pkg::GEN_W-1:0]     mem_generation [DEPTH];

    logic [DEPTH-1:0]               valid_reg;
    logic [DEPTH-1:0]               valid_next;
    logic                           rd_valid_reg;
    rwlt_pkg::slot_state_t          q_state_reg;
    logic [RD_W-1:0]                q_readers_reg;
    logic [OWN_W-1:0]               q_intent_reg;
    logic [OWN_W-1:0]               q_write_reg;
    logic [rwlt_pkg::GEN_W-1:0]     q_generation_reg;
    logic                           bypass;

    assign bypass = rd_en && wr_en && (rd_addr == wr_addr);

    always_comb begin
        valid_next = valid_reg;
        if (wr_en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (rd_en) begin
                rd_valid_reg <= bypass ? 1'b1 : valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_state[wr_addr]      <= wr_state;
            mem_readers[wr_addr]    <= wr_readers;
            mem_intent[wr_addr]     <= wr_intent_owner;
            mem_write[wr_addr]      <= wr_write_owner;
            mem_generation[wr_addr] <= wr_generation;
        end
        if (rd_en) begin
            if (bypass) begin
                q_state_reg      <= wr_state;
                q_readers_reg    <= wr_readers;
                q_intent_reg     <= wr_intent_owner;
                q_write_reg      <= wr_write_owner;
                q_generation_reg <= wr_generation;
            end else begin
                q_state_reg      <= mem_state[rd_addr];
                q_readers_reg    <= mem_readers[rd_addr];
                q_intent_reg     <= mem_intent[rd_addr];
                q_write_reg      <= mem_write[rd_addr];
                q_generation_reg <= mem_generation[rd_addr];
            end
        end
    end

    // A slot never written since reset reads as absent with all fields zero.
    assign rd_state        = rd_valid_reg ? q_state_reg : rwlt_pkg::ST_ABSENT;
    assign rd_readers      = rd_valid_reg ? q_readers_reg : '0;
    assign rd_intent_owner = rd_valid_reg ? q_intent_reg : '0;
    assign rd_write_owner  = rd_valid_reg ? q_write_reg : '0;
    assign rd_generation   = rd_valid_reg ? q_generation_reg : '0;

endmodule

// ===== hdl/rwlt_engine.sv =====
`timescale 1ns / 1ps

module rwlt_engine #(
    parameter int RD_W        = 8,
    parameter int OWN_W       = 9,
    parameter int MAX_READERS = 255
) (
    input  logic                       in_range,
    input  rwlt_pkg::op_t              op,
    input  logic [rwlt_pkg::GEN_W-1:0] handle_id,
    input  logic [OWN_W-1:0]           mine,
    input  rwlt_pkg::slot_state_t      cur_state,
    input  logic [RD_W-1:0]            cur_readers,
    input  logic [OWN_W-1:0]           cur_intent_owner,
    input  logic [OWN_W-1:0]           cur_write_owner,
    input  logic [rwlt_pkg::GEN_W-1:0] cur_generation,
    input  logic [rwlt_pkg::GEN_W-1:0] gen_counter,
    output rwlt_pkg::slot_state_t      nxt_state,
    output logic [RD_W-1:0]            nxt_readers,
    output logic [OWN_W-1:0]           nxt_intent_owner,
    output logic [OWN_W-1:0]           nxt_write_owner,
    output logic [rwlt_pkg::GEN_W-1:0] nxt_generation,
    output logic [rwlt_pkg::GEN_W-1:0] gen_counter_next,
    output logic [rwlt_pkg::GEN_W-1:0] new_id,
    output rwlt_pkg::eng_ctl_t         ctl
);

    logic            id_ok;
    logic            at_limit;
    logic [RD_W-1:0] dec_readers;
    logic [rwlt_pkg::GEN_W-1:0] gen_inc;

    assign id_ok    = (cur_state != rwlt_pkg::ST_ABSENT) && (handle_id != '0)
                      && (handle_id == cur_generation);
    assign at_limit = (cur_readers >= RD_W'(MAX_READERS));
    assign dec_readers = (cur_readers != '0) ? cur_readers - RD_W'(1) : '0;
    assign gen_inc  = gen_counter + rwlt_pkg::GEN_W'(1);

    always_comb begin
        nxt_state        = cur_state;
        nxt_readers      = cur_readers;
        nxt_intent_owner = cur_intent_owner;
        nxt_write_owner  = cur_write_owner;
        nxt_generation   = cur_generation;
        gen_counter_next = (gen_inc == '0) ? rwlt_pkg::GEN_W'(1) : gen_inc;
        new_id           = '0;
        ctl.status       = rwlt_pkg::RS_GRANTED;
        ctl.wake         = rwlt_pkg::WK_NONE;
        ctl.gen_advance  = 1'b0;

        if (!in_range) begin
            ctl.status = rwlt_pkg::RS_NOLOCK;
        end else if (op == rwlt_pkg::OP_CREATE) begin
            if (cur_state != rwlt_pkg::ST_ABSENT) begin
                ctl.status = rwlt_pkg::RS_MISUSE;
            end else begin
                nxt_state        = rwlt_pkg::ST_FREE;
                nxt_readers      = '0;
                nxt_intent_owner = '0;
                nxt_write_owner  = '0;
                nxt_generation   = gen_counter;
                new_id           = gen_counter;
                ctl.gen_advance  = 1'b1;
            end
        end else if (!id_ok) begin
            ctl.status = rwlt_pkg::RS_NOLOCK;
        end else begin
            case (op)
                rwlt_pkg::OP_UNLOCK: begin
                    if (cur_state == rwlt_pkg::ST_FREE) begin
                        ctl.status = rwlt_pkg::RS_MISUSE;
                    end else if (cur_state == rwlt_pkg::ST_WRITE) begin
                        if (cur_write_owner != mine) begin
                            ctl.status = rwlt_pkg::RS_NOTOWNER;
                        end else begin
                            nxt_write_owner = '0;
                            nxt_readers     = '0;
                            nxt_state       = rwlt_pkg::ST_FREE;
                            ctl.wake        = rwlt_pkg::WK_ALL;
                        end
                    end else if (cur_state == rwlt_pkg::ST_READ) begin
                        nxt_readers = dec_readers;
                        if (dec_readers == '0) begin
                            nxt_state = rwlt_pkg::ST_FREE;
                            ctl.wake  = rwlt_pkg::WK_ONE;
                        end
                    end else begin
                        nxt_readers = dec_readers;
                        if (dec_readers == '0) begin
                            nxt_state        = rwlt_pkg::ST_FREE;
                            nxt_intent_owner = '0;
                        end else if (cur_intent_owner == mine) begin
                            nxt_state        = rwlt_pkg::ST_READ;
                            nxt_intent_owner = '0;
                        end
                        ctl.wake = rwlt_pkg::WK_ALL;
                    end
                end
                rwlt_pkg::OP_READ: begin
                    if (cur_state == rwlt_pkg::ST_WRITE || at_limit) begin
                        ctl.status = rwlt_pkg::RS_WAIT;
                    end else begin
                        nxt_readers = cur_readers + RD_W'(1);
                        if (cur_state == rwlt_pkg::ST_FREE) begin
                            nxt_state = rwlt_pkg::ST_READ;
                        end
                    end
                end
                rwlt_pkg::OP_INTENT: begin
                    if (cur_state == rwlt_pkg::ST_WRITE || cur_state == rwlt_pkg::ST_INTENT
                        || at_limit) begin
                        ctl.status = rwlt_pkg::RS_WAIT;
                    end else begin
                        nxt_intent_owner = mine;
                        nxt_readers      = cur_readers + RD_W'(1);
                        nxt_state        = rwlt_pkg::ST_INTENT;
                    end
                end
                rwlt_pkg::OP_PROMOTE: begin
                    if (cur_state != rwlt_pkg::ST_INTENT) begin
                        ctl.status = rwlt_pkg::RS_MISUSE;
                    end else if (cur_intent_owner != mine) begin
                        ctl.status = rwlt_pkg::RS_NOTOWNER;
                    end else if (cur_readers != RD_W'(1)) begin
                        ctl.status = rwlt_pkg::RS_WAIT;
                    end else begin
                        nxt_readers      = '0;
                        nxt_state        = rwlt_pkg::ST_WRITE;
                        nxt_intent_owner = '0;
                        nxt_write_owner  = mine;
                    end
                end
                rwlt_pkg::OP_WRITE: begin
                    if (cur_state != rwlt_pkg::ST_FREE) begin
                        ctl.status = rwlt_pkg::RS_WAIT;
                    end else begin
                        nxt_readers     = '0;
                        nxt_state       = rwlt_pkg::ST_WRITE;
                        nxt_write_owner = mine;
                    end
                end
                rwlt_pkg::OP_DEMOTE: begin
                    if (cur_state != rwlt_pkg::ST_WRITE) begin
                        ctl.status = rwlt_pkg::RS_MISUSE;
                    end else if (cur_write_owner != mine) begin
                        ctl.status = rwlt_pkg::RS_NOTOWNER;
                    end else begin
                        nxt_write_owner  = '0;
                        nxt_intent_owner = mine;
                        nxt_state        = rwlt_pkg::ST_INTENT;
                        nxt_readers      = RD_W'(1);
                        ctl.wake         = rwlt_pkg::WK_ALL;
                    end
                end
                default: begin
                    if (cur_state != rwlt_pkg::ST_FREE) begin
                        ctl.status = rwlt_pkg::RS_MISUSE;
                    end else begin
                        nxt_state        = rwlt_pkg::ST_ABSENT;
                        nxt_readers      = '0;
                        nxt_intent_owner = '0;
                        nxt_write_owner  = '0;
                        nxt_generation   = '0;
                    end
                end
            endcase
        end

        ctl.write_en = in_range && (ctl.status == rwlt_pkg::RS_GRANTED);
    end

endmodule

// ===== tb/sv/read_intend_write_lock_table_tb.sv =====
`timescale 1ns / 1ps

module read_intend_write_lock_table_tb;

    import rwlt_pkg::*;

    localparam int NUM_SLOTS    = 64;
    localparam int READER_LIMIT = 255;
    localparam int RANDOM_ITEMS = 1070;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        status_t     status;
        wake_t       wake;
        slot_state_t state;
        logic [8:0]  count;
        logic [15:0] new_id;
    } lock_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    slot_state_t lk_state   [NUM_SLOTS];
    logic [7:0]  lk_readers [NUM_SLOTS];
    logic [8:0]  lk_intent  [NUM_SLOTS];
    logic [8:0]  lk_writer  [NUM_SLOTS];
    logic [15:0] lk_gen     [NUM_SLOTS];
    logic [15:0] lk_gen_counter;

    lock_result_t awaited_results[$];
    int           mismatches;
    int           words_checked;
    int           cycle_count;
    int           hold_off_cycles;
    bit           tx_idle;
    bit           rx_idle;

    read_intend_write_lock_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    // Applies one request to the lock table copy and returns the result it must produce.
    function automatic lock_result_t apply_request(op_t op, logic [5:0] idx, logic [15:0] id,
                                                   logic [7:0] who);
        lock_result_t r;
        slot_state_t  st;
        logic [8:0]   mine;
        r.status = RS_GRANTED;
        r.wake   = WK_NONE;
        r.new_id = '0;
        st       = lk_state[idx];
        mine     = {1'b1, who};
        if (op == OP_CREATE) begin
            if (st != ST_ABSENT) begin
                r.status = RS_MISUSE;
            end else begin
                lk_state[idx]   = ST_FREE;
                lk_readers[idx] = '0;
                lk_intent[idx]  = '0;
                lk_writer[idx]  = '0;
                lk_gen[idx]     = lk_gen_counter;
                r.new_id        = lk_gen_counter;
                lk_gen_counter  = lk_gen_counter + 16'd1;
                if (lk_gen_counter == 16'd0) begin
                    lk_gen_counter = 16'd1;
                end
            end
        end else if (st == ST_ABSENT || id == 16'd0 || id != lk_gen[idx]) begin
            r.status = RS_NOLOCK;
        end else begin
            case (op)
                OP_UNLOCK: begin
                    if (st == ST_FREE) begin
                        r.status = RS_MISUSE;
                    end else if (st == ST_WRITE) begin
                        if (lk_writer[idx] != mine) begin
                            r.status = RS_NOTOWNER;
                        end else begin
                            lk_writer[idx]  = '0;
                            lk_readers[idx] = '0;
                            lk_state[idx]   = ST_FREE;
                            r.wake          = WK_ALL;
                        end
                    end else if (st == ST_READ) begin
                        if (lk_readers[idx] != 0) begin
                            lk_readers[idx] = lk_readers[idx] - 8'd1;
                        end
                        if (lk_readers[idx] == 0) begin
                            lk_state[idx] = ST_FREE;
                            r.wake        = WK_ONE;
                        end
                    end else begin
                        if (lk_readers[idx] != 0) begin
                            lk_readers[idx] = lk_readers[idx] - 8'd1;
                        end
                        if (lk_readers[idx] == 0) begin
                            lk_state[idx]  = ST_FREE;
                            lk_intent[idx] = '0;
                        end else if (lk_intent[idx] == mine) begin
                            lk_state[idx]  = ST_READ;
                            lk_intent[idx] = '0;
                        end
                        r.wake = WK_ALL;
                    end
                end
                OP_READ: begin
                    if (st == ST_WRITE || lk_readers[idx] >= READER_LIMIT) begin
                        r.status = RS_WAIT;
                    end else begin
                        lk_readers[idx] = lk_readers[idx] + 8'd1;
                        if (st == ST_FREE) begin
                            lk_state[idx] = ST_READ;
                        end
                    end
                end
                OP_INTENT: begin
                    if (st == ST_WRITE || st == ST_INTENT || lk_readers[idx] >= READER_LIMIT) begin
                        r.status = RS_WAIT;
                    end else begin
                        lk_intent[idx]  = mine;
                        lk_readers[idx] = lk_readers[idx] + 8'd1;
                        lk_state[idx]   = ST_INTENT;
                    end
                end
                OP_PROMOTE: begin
                    if (st != ST_INTENT) begin
                        r.status = RS_MISUSE;
                    end else if (lk_intent[idx] != mine) begin
                        r.status = RS_NOTOWNER;
                    end else if (lk_readers[idx] != 8'd1) begin
                        r.status = RS_WAIT;
                    end else begin
                        lk_readers[idx] = '0;
                        lk_state[idx]   = ST_WRITE;
                        lk_intent[idx]  = '0;
                        lk_writer[idx]  = mine;
                    end
                end
                OP_WRITE: begin
                    if (st != ST_FREE) begin
                        r.status = RS_WAIT;
                    end else begin
                        lk_readers[idx] = '0;
                        lk_state[idx]   = ST_WRITE;
                        lk_writer[idx]  = mine;
                    end
                end
                OP_DEMOTE: begin
                    if (st != ST_WRITE) begin
                        r.status = RS_MISUSE;
                    end else if (lk_writer[idx] != mine) begin
                        r.status = RS_NOTOWNER;
                    end else begin
                        lk_writer[idx]  = '0;
                        lk_intent[idx]  = mine;
                        lk_state[idx]   = ST_INTENT;
                        lk_readers[idx] = 8'd1;
                        r.wake          = WK_ALL;
                    end
                end
                default: begin
                    if (st != ST_FREE) begin
                        r.status = RS_MISUSE;
                    end else begin
                        lk_state[idx]   = ST_ABSENT;
                        lk_readers[idx] = '0;
                        lk_intent[idx]  = '0;
                        lk_writer[idx]  = '0;
                        lk_gen[idx]     = '0;
                    end
                end
            endcase
        end
        r.state = lk_state[idx];
        r.count = (r.state == ST_WRITE) ? 9'h1FF : {1'b0, lk_readers[idx]};
        return r;
    endfunction

    // Mostly requests with the slot's live id on a few busy slots, so the locks go deep.
    function automatic void pick_request(output op_t op, output logic [5:0] idx,
                                         output logic [15:0] id, output logic [7:0] who);
        idx = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
        who = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        if (lk_state[idx] == ST_ABSENT && $urandom_range(0, 99) < 60) begin
            op = OP_CREATE;
        end else begin
            op = op_t'($urandom_range(0, 7));
        end
        id = ($urandom_range(0, 99) < 90) ? lk_gen[idx] : 16'($urandom);
    endfunction

    task automatic report(string what);
        mismatches++;
        if (mismatches <= 200) begin
            $display("mismatch: %s", what);
        end
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report($sformatf("word %0d %s: expected %0d, got %0d", words_checked, name, want, got));
        end
    endtask

    task automatic send_request(input op_t op, input logic [5:0] idx, input logic [15:0] id,
                                input logic [7:0] who, output lock_result_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {7'd0, who, id, idx, op};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = apply_request(op, idx, id, who);
        awaited_results.push_back(r);
    endtask

    task automatic test_directed();
        lock_result_t r;
        logic [15:0]  g;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_request(OP_READ, 6'd0, 16'd0, 8'd0, r);
        send_request(OP_CREATE, 6'd0, 16'hFFFF, 8'd0, r);
        g = r.new_id;
        send_request(OP_CREATE, 6'd0, 16'd0, 8'd0, r);
        send_request(OP_READ, 6'd0, 16'd0, 8'd3, r);
        send_request(OP_READ, 6'd0, ~g, 8'd3, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd3, r);
        send_request(OP_PROMOTE, 6'd0, g, 8'd3, r);
        send_request(OP_READ, 6'd0, g, 8'd3, r);
        send_request(OP_INTENT, 6'd0, g, 8'd5, r);
        send_request(OP_INTENT, 6'd0, g, 8'd6, r);
        send_request(OP_PROMOTE, 6'd0, g, 8'd3, r);
        send_request(OP_PROMOTE, 6'd0, g, 8'd5, r);
        send_request(OP_WRITE, 6'd0, g, 8'd3, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd3, r);
        send_request(OP_PROMOTE, 6'd0, g, 8'd5, r);
        send_request(OP_DEMOTE, 6'd0, g, 8'd3, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd9, r);
        send_request(OP_DEMOTE, 6'd0, g, 8'd5, r);
        send_request(OP_DELETE, 6'd0, g, 8'd5, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd5, r);
        send_request(OP_WRITE, 6'd0, g, 8'hFF, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'hFF, r);
        send_request(OP_INTENT, 6'd0, g, 8'd0, r);
        send_request(OP_READ, 6'd0, g, 8'd1, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd0, r);
        send_request(OP_UNLOCK, 6'd0, g, 8'd1, r);
        send_request(OP_DELETE, 6'd0, g, 8'd1, r);
        send_request(OP_CREATE, 6'd63, 16'hFFFF, 8'hFF, r);
    endtask

    task automatic test_reader_limit();
        lock_result_t r;
        logic [15:0]  g;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_request(OP_CREATE, 6'd62, 16'd0, 8'd0, r);
        g = r.new_id;
        send_request(OP_INTENT, 6'd62, g, 8'd7, r);
        repeat (READER_LIMIT - 1) send_request(OP_READ, 6'd62, g, 8'($urandom), r);
        send_request(OP_READ, 6'd62, g, 8'd1, r);
        send_request(OP_INTENT, 6'd62, g, 8'd2, r);
        send_request(OP_PROMOTE, 6'd62, g, 8'd7, r);
    endtask

    task automatic test_backpressure();
        lock_result_t r;
        op_t          op;
        logic [5:0]   idx;
        logic [15:0]  id;
        logic [7:0]   who;
        tx_idle         = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (40) begin
            pick_request(op, idx, id, who);
            send_request(op, idx, id, who, r);
        end
    endtask

    task automatic test_random_traffic();
        lock_result_t r;
        op_t          op;
        logic [5:0]   idx;
        logic [15:0]  id;
        logic [7:0]   who;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0) begin
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
            end
            pick_request(op, idx, id, who);
            send_request(op, idx, id, who, r);
        end
    endtask

    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles != 0) begin
                m_tready = 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                m_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        lock_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report($sformatf("word %0d arrived with nothing outstanding: %h",
                                 words_checked, m_tdata));
            end else begin
                e = awaited_results.pop_front();
                check_field("status", 16'(m_tdata[2:0]), 16'(e.status));
                check_field("wake", 16'(m_tdata[4:3]), 16'(e.wake));
                check_field("new_state", 16'(m_tdata[7:5]), 16'(e.state));
                check_field("reader_count", 16'(m_tdata[16:8]), 16'(e.count));
                check_field("new_id", m_tdata[32:17], e.new_id);
            end
            words_checked++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        tx_idle         = 1'b0;
        rx_idle         = 1'b0;
        hold_off_cycles = 0;
        mismatches      = 0;
        words_checked   = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            lk_state[i]   = ST_ABSENT;
            lk_readers[i] = '0;
            lk_intent[i]  = '0;
            lk_writer[i]  = '0;
            lk_gen[i]     = '0;
        end
        lk_gen_counter = 16'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_reader_limit();
        test_backpressure();
        test_random_traffic();

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
